### rtl/core/hsfc_pkg.sv
// Package for the half/single float converter core.
// Holds the opcode and shift-kind codes, the inter-stage structs and format constants.
// Has no dependencies.
`default_nettype none

package hsfc_pkg;

  typedef enum logic {
    OP_H2S = 1'b0,
    OP_S2H = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SHIFT_NONE  = 2'd0,
    SHIFT_LEFT  = 2'd1,
    SHIFT_RIGHT = 2'd2
  } shift_e;

  localparam logic [4:0] HalfExpMax   = 5'h1F;
  localparam logic [7:0] SingleExpMax = 8'hFF;
  localparam logic [7:0] HalfToSingle = 8'd112;
  localparam logic [7:0] SubnormBase  = 8'd113;
  localparam logic [7:0] OverflowExp  = 8'd143;
  localparam logic [7:0] UnderflowExp = 8'd102;

  typedef struct packed {
    op_e        op;
    logic       sign;
    shift_e     shift;
    logic [3:0] shamt;
    logic [7:0] expo;
    logic [9:0] frac;
    logic       nan;
  } dec_t;

  typedef struct packed {
    op_e        op;
    logic       sign;
    logic [7:0] expo;
    logic [9:0] frac;
    logic       nan;
  } aln_t;

endpackage

`default_nettype wire

### rtl/core/half_single_float_converter_core.sv
// Top level of the half/single float converter core.
// Chains hsfc_decode, hsfc_align and hsfc_pack; depends on hsfc_pkg.
//
// Usage:
//   Raise start_i with opcode_i and operand_bits_i; the transaction is taken at
//   that rising edge (busy_o is always low, so every start is taken).
//   opcode_i = 0 converts the half in operand_bits_i[15:0] to single,
//   opcode_i = 1 converts the single in operand_bits_i to half (truncating).
//   The result appears on result_bits_o for one cycle with done_o high, after
//   passing the decode, align and pack registers in that order;
//   half results sit in bits 15:0.
//   Throughput is one transaction per cycle: three register stages
//   (decode, align, pack) each pass one item per cycle.
//   Results leave in start order. The receiver cannot stall, so a result is
//   taken in the cycle done_o is high.
//   Reset (rst_ni low) clears all stage valid bits; items in flight are dropped.
`default_nettype none

module half_single_float_converter_core
  import hsfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] operand_bits_i,
  output logic             done_o,
  output logic [31:0]      result_bits_o
);

  logic dec_valid;
  dec_t dec;
  logic aln_valid;
  aln_t aln;

  assign busy_o = 1'b0;

  hsfc_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (start_i),
    .opcode_i       (opcode_i),
    .operand_bits_i (operand_bits_i),
    .valid_o        (dec_valid),
    .dec_o          (dec)
  );

  hsfc_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .dec_i   (dec),
    .valid_o (aln_valid),
    .aln_o   (aln)
  );

  hsfc_pack u_pack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (aln_valid),
    .aln_i    (aln),
    .valid_o  (done_o),
    .result_o (result_bits_o)
  );

endmodule

`default_nettype wire

### rtl/core/hsfc_decode.sv
// First stage of the converter: classifies the operand and computes exponent and shift.
// Depends on hsfc_pkg.
`default_nettype none

module hsfc_decode
  import hsfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic        opcode_i,
  input  wire logic [31:0] operand_bits_i,
  output logic             valid_o,
  output dec_t             dec_o
);

  logic       valid_q;
  dec_t       dec_d, dec_q;
  logic [4:0] h_exp;
  logic [9:0] h_man;
  logic [7:0] s_exp;
  logic [3:0] lz;

  assign h_exp = operand_bits_i[14:10];
  assign h_man = operand_bits_i[9:0];
  assign s_exp = operand_bits_i[30:23];

  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) begin
        lz = 4'(10 - i);
      end
    end
  end

  always_comb begin
    dec_d       = '0;
    dec_d.op    = op_e'(opcode_i);
    dec_d.shift = SHIFT_NONE;
    if (op_e'(opcode_i) == OP_H2S) begin
      dec_d.sign = operand_bits_i[15];
      dec_d.frac = h_man;
      if (h_exp == 5'd0) begin
        if (h_man != 10'd0) begin
          dec_d.shift = SHIFT_LEFT;
          dec_d.shamt = lz;
          dec_d.expo  = SubnormBase - {4'd0, lz};
        end
      end else if (h_exp == HalfExpMax) begin
        dec_d.expo = SingleExpMax;
        dec_d.nan  = (h_man != 10'd0);
      end else begin
        dec_d.expo = {3'd0, h_exp} + HalfToSingle;
      end
    end else begin
      dec_d.sign = operand_bits_i[31];
      if (s_exp == SingleExpMax) begin
        dec_d.expo = {3'd0, HalfExpMax};
        dec_d.frac = operand_bits_i[22:13];
        dec_d.nan  = (operand_bits_i[22:0] != 23'd0);
      end else if (s_exp == 8'd0 || s_exp < UnderflowExp) begin
        dec_d.frac = 10'd0;
      end else if (s_exp >= OverflowExp) begin
        dec_d.expo = {3'd0, HalfExpMax};
      end else if (s_exp < SubnormBase) begin
        dec_d.shift = SHIFT_RIGHT;
        dec_d.shamt = 4'(SubnormBase - s_exp);
        dec_d.frac  = operand_bits_i[22:13];
      end else begin
        dec_d.expo = s_exp - HalfToSingle;
        dec_d.frac = operand_bits_i[22:13];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

### rtl/core/hsfc_align.sv
// Second stage of the converter: normalizes half subnormals and denormalizes small singles.
// Depends on hsfc_pkg.
`default_nettype none

module hsfc_align
  import hsfc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  wire dec_t dec_i,
  output logic      valid_o,
  output aln_t      aln_o
);

  logic        valid_q;
  aln_t        aln_d, aln_q;
  logic [10:0] shl;
  logic [10:0] shr;

  assign shl = {1'b0, dec_i.frac} << dec_i.shamt;
  assign shr = {1'b1, dec_i.frac} >> dec_i.shamt;

  always_comb begin
    aln_d.op   = dec_i.op;
    aln_d.sign = dec_i.sign;
    aln_d.expo = dec_i.expo;
    aln_d.nan  = dec_i.nan;
    unique case (dec_i.shift)
      SHIFT_LEFT:  aln_d.frac = shl[9:0];
      SHIFT_RIGHT: aln_d.frac = shr[9:0];
      default:     aln_d.frac = dec_i.frac;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    aln_q <= aln_d;
  end

  assign valid_o = valid_q;
  assign aln_o   = aln_q;

endmodule

`default_nettype wire

### rtl/core/hsfc_pack.sv
// Last stage of the converter: packs sign, exponent and fraction into the result word.
// Depends on hsfc_pkg.
`default_nettype none

module hsfc_pack
  import hsfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire aln_t        aln_i,
  output logic             valid_o,
  output logic [31:0]      result_o
);

  logic        valid_q;
  logic [31:0] result_d, result_q;

  always_comb begin
    unique case (aln_i.op)
      OP_H2S:  result_d = {aln_i.sign, aln_i.expo, aln_i.frac, 12'd0, aln_i.nan};
      default: result_d = {16'd0, aln_i.sign, aln_i.expo[4:0],
                           aln_i.frac[9:1], aln_i.frac[0] | aln_i.nan};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire
